/* rtl/ksci_pkg.sv */
// Shared types, character codes and key table for the keypad slot command indexer.
`timescale 1ns / 1ps

package ksci_pkg;

  // Key code of the '*' key, which closes an entry.
  localparam logic [3:0] KEY_STAR = 4'd12;

  // Number of leading entry characters that the checker looks at.
  localparam int unsigned HEAD_LEN = 3;

  // Character codes used by the entry checks.
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_7    = 8'h37;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_HASH = 8'h23;

  // Largest step count that fits the output field.
  localparam logic [14:0] STEP_LIMIT = 15'h7FFF;

  // Reset value of the steps-per-slot register.
  localparam logic [11:0] STEPS_RESET = 12'd402;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_LONG   = 2'd1,
    ST_BAD_READER = 2'd2,
    ST_BAD_CARD   = 2'd3
  } status_e;

  // One result item as it sits in the output register.
  typedef struct packed {
    status_e     status;
    logic [4:0]  target_slot;
    logic [1:0]  reader_index;
    logic [14:0] step_count;
    logic        backward;
  } res_t;

  // Keypad matrix, row-major: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D.
  function automatic logic [7:0] key_char(input logic [3:0] code);
    logic [7:0] ch;
    case (code)
      4'd0:    ch = 8'h31;
      4'd1:    ch = 8'h32;
      4'd2:    ch = 8'h33;
      4'd3:    ch = 8'h41;
      4'd4:    ch = 8'h34;
      4'd5:    ch = 8'h35;
      4'd6:    ch = 8'h36;
      4'd7:    ch = 8'h42;
      4'd8:    ch = 8'h37;
      4'd9:    ch = 8'h38;
      4'd10:   ch = 8'h39;
      4'd11:   ch = 8'h43;
      4'd12:   ch = CH_STAR;
      4'd13:   ch = CH_0;
      4'd14:   ch = CH_HASH;
      default: ch = CH_D;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/ksci_entry_buf.sv */
// Entry character buffer and length counter of the keypad slot command indexer.
`timescale 1ns / 1ps

module ksci_entry_buf #(
  parameter int unsigned ENTRY_MAX = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  logic [3:0]                         key_i,
  input  logic                               clear_i,
  output logic [ksci_pkg::HEAD_LEN-1:0][3:0] head_o,
  output logic                               long_o,
  output logic [1:0]                         short_len_o
);
  import ksci_pkg::*;

  localparam int unsigned LenW = $clog2(ENTRY_MAX + 1);
  localparam int unsigned IdxW = $clog2(ENTRY_MAX);

  logic [3:0]      chars_q [ENTRY_MAX];
  logic [LenW-1:0] len_q;
  logic [LenW-1:0] len_d;
  logic            has_room;

  assign has_room = len_q < LenW'(ENTRY_MAX);

  // Length counter: a closing key empties the buffer, extra keys are dropped.
  always_comb begin
    len_d = len_q;
    if (clear_i) begin
      len_d = '0;
    end else if (push_i && has_room) begin
      len_d = len_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  // Character storage; entries at or above the length are never looked at.
  always_ff @(posedge clk_i) begin
    if (push_i && has_room) begin
      chars_q[len_q[IdxW-1:0]] <= key_i;
    end
  end

  // The checker only needs the first characters and a coarse length.
  always_comb begin
    for (int i = 0; i < HEAD_LEN; i++) begin
      head_o[i] = chars_q[i];
    end
  end

  assign long_o      = len_q > LenW'(HEAD_LEN);
  assign short_len_o = len_q[1:0];

endmodule

/* rtl/ksci_eval.sv */
// Entry check, slot clamp, ring distance and step count for one closing key.
`timescale 1ns / 1ps

module ksci_eval #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic [ksci_pkg::HEAD_LEN-1:0][3:0] head_i,
  input  logic                               long_i,
  input  logic [1:0]                         short_len_i,
  input  logic [4:0]                         cur_slot_i,
  input  logic [11:0]                        steps_per_slot_i,
  output ksci_pkg::res_t                     res_o
);
  import ksci_pkg::*;

  // Highest slot a card can reach; card numbers stop at sixteen.
  localparam logic [4:0]        SlotClamp = (SLOT_COUNT < 16) ? 5'(SLOT_COUNT) : 5'd16;
  localparam logic signed [7:0] SlotRing  = 8'(SLOT_COUNT);
  localparam logic signed [7:0] SlotHalf  = 8'(SLOT_COUNT / 2);

  logic [7:0]        c0, c1, c2, last_ch;
  logic              has_last, reader_ok, card_ok;
  logic [3:0]        units;
  logic [4:0]        pos, target;
  logic signed [7:0] diff_raw, diff;
  logic [7:0]        mag;
  logic [15:0]       prod;
  logic [14:0]       steps;

  // Assemble the characters; a two-key entry gets a leading zero.
  always_comb begin
    c0 = '0;
    c1 = '0;
    c2 = '0;
    case (short_len_i)
      2'd1: begin
        c0 = key_char(head_i[0]);
      end
      2'd2: begin
        c0 = CH_0;
        c1 = key_char(head_i[0]);
        c2 = key_char(head_i[1]);
      end
      2'd3: begin
        c0 = key_char(head_i[0]);
        c1 = key_char(head_i[1]);
        c2 = key_char(head_i[2]);
      end
      default: begin
        c0 = '0;
      end
    endcase
  end

  // The reader letter is the last character; an empty entry has none.
  assign has_last  = short_len_i != 2'd0;
  assign last_ch   = (short_len_i == 2'd1) ? c0 : c2;
  assign reader_ok = has_last && (last_ch >= CH_A) && (last_ch <= CH_D);

  // Card number 00..16.
  assign card_ok = ((c0 == CH_0) || (c0 == CH_1)) && (c1 >= CH_0) && (c1 <= CH_9) &&
                   !((c0 == CH_1) && (c1 >= CH_7));

  assign units = 4'(c1 - CH_0);
  assign pos   = (c0 == CH_1) ? (5'd10 + {1'b0, units}) : {1'b0, units};

  // Clamp onto the ring, then take the shorter way round.
  always_comb begin
    target = pos;
    if (pos > SlotClamp) begin
      target = SlotClamp;
    end
    if (pos == 5'd0) begin
      target = 5'd1;
    end
  end

  assign diff_raw = $signed({3'b000, target}) - $signed({3'b000, cur_slot_i});

  always_comb begin
    diff = diff_raw;
    if (diff_raw > SlotHalf) begin
      diff = diff_raw - SlotRing;
    end else if (diff_raw < -SlotHalf) begin
      diff = diff_raw + SlotRing;
    end
  end

  // The distance never exceeds fifteen slots, so four bits feed the multiplier.
  assign mag   = diff[7] ? 8'(-diff) : 8'(diff);
  assign prod  = 16'(mag[3:0]) * 16'(steps_per_slot_i);
  assign steps = prod[15] ? STEP_LIMIT : prod[14:0];

  // Checks in order: length, reader letter, card number.
  always_comb begin
    res_o = '0;
    if (long_i) begin
      res_o.status = ST_TOO_LONG;
    end else if (!reader_ok) begin
      res_o.status = ST_BAD_READER;
    end else if (!card_ok) begin
      res_o.status = ST_BAD_CARD;
    end else begin
      res_o.status       = ST_OK;
      res_o.target_slot  = target;
      res_o.reader_index = last_ch[1:0] - CH_A[1:0];
      res_o.step_count   = steps;
      res_o.backward     = diff[7];
    end
  end

endmodule

/* rtl/keypad_slot_command_indexer.sv */
// Top level of the keypad slot command indexer: input register, buffer, checker, result register.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid_i / in_ready_o / key_code_i) carries one decoded
// keypad key per transfer. Keys other than '*' are buffered and give no result.
// A '*' key checks the buffered entry and produces exactly one result transfer on
// the output channel (out_valid_o / out_ready_i fields), then clears the buffer.
// The user is to write the steps-per-slot register through cfg_we_i / cfg_wdata_i
// while idle; the block does not enforce this. A result passes one input register,
// one combinational check and one result register. One key per cycle unless a '*'
// waits on a stalled result; the step count comes from one 4 x 12 multiply.
// At reset the buffer is empty, the current slot is 1 and steps per slot is 402.
// When the receiver stalls, the result register holds its item; further non-'*' keys
// keep flowing into the buffer, and only a second '*' waits in the input register,
// which then drops in_ready_o until the stalled result is taken.
// Invalid entries report their status and leave the current slot unchanged.

module keypad_slot_command_indexer #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned ENTRY_MAX  = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  key_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [4:0]  target_slot_o,
  output logic [1:0]  reader_index_o,
  output logic [14:0] step_count_o,
  output logic        backward_o,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i
);
  import ksci_pkg::*;

  localparam logic [4:0] SlotClamp = (SLOT_COUNT < 16) ? 5'(SLOT_COUNT) : 5'd16;

  logic                        in_vld_q;
  logic [3:0]                  key_q;
  logic                        is_star, out_free, advance;
  logic                        load_res;
  logic [HEAD_LEN-1:0][3:0]    head;
  logic                        entry_long;
  logic [1:0]                  short_len;
  logic [4:0]                  cur_slot_q;
  logic [11:0]                 sps_q;
  res_t                        res_d, res_q;
  logic                        out_vld_q;

  // Handshake: a key leaves the input register unless it is a '*' facing a full output.
  assign is_star    = key_q == KEY_STAR;
  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && (!is_star || out_free);
  assign in_ready_o = !in_vld_q || advance;
  assign load_res   = advance && is_star;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      key_q <= key_code_i;
    end
  end

  // Steps-per-slot configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sps_q <= STEPS_RESET;
    end else if (cfg_we_i) begin
      sps_q <= cfg_wdata_i;
    end
  end

  ksci_entry_buf #(
    .ENTRY_MAX (ENTRY_MAX)
  ) u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance && !is_star),
    .key_i       (key_q),
    .clear_i     (load_res),
    .head_o      (head),
    .long_o      (entry_long),
    .short_len_o (short_len)
  );

  ksci_eval #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_eval (
    .head_i           (head),
    .long_i           (entry_long),
    .short_len_i      (short_len),
    .cur_slot_i       (cur_slot_q),
    .steps_per_slot_i (sps_q),
    .res_o            (res_d)
  );

  // Result register and current slot; only a good entry moves the slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      cur_slot_q <= 5'd1;
    end else begin
      if (load_res) begin
        out_vld_q <= 1'b1;
        if (res_d.status == ST_OK) begin
          cur_slot_q <= res_d.target_slot;
        end
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = res_q.status;
  assign target_slot_o  = res_q.target_slot;
  assign reader_index_o = res_q.reader_index;
  assign step_count_o   = res_q.step_count;
  assign backward_o     = res_q.backward;

  // The current slot always stays on the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_slot_q >= 5'd1) && (cur_slot_q <= SlotClamp))
    else $error("current slot left the ring");

  // A good result on the output names the slot the carousel now stands at.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.status == ST_OK)) |-> (res_q.target_slot == cur_slot_q))
    else $error("good result disagrees with current slot");

  // A failed entry carries no slot, reader, steps or direction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.status != ST_OK)) |->
      ((res_q.target_slot == '0) && (res_q.reader_index == '0) &&
       (res_q.step_count == '0) && !res_q.backward))
    else $error("failed entry carries payload");

  // The input side only stalls behind a '*' that faces a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && is_star && out_vld_q && !out_ready_i))
    else $error("input stalled without cause");

endmodule

/* sim/keypad_slot_command_indexer_tb.sv */
// Self-checking testbench for the keypad slot command indexer.
`timescale 1ns / 1ps

module keypad_slot_command_indexer_tb;
  import ksci_pkg::*;

  localparam int RING_SLOTS = 16;
  localparam int ENTRY_DEPTH = 5;
  localparam int unsigned RANDOM_KEYS = 1600;
  localparam int unsigned PHASES = 6;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT = 10;

  // Key codes of the 4x4 matrix, row-major.
  localparam logic [3:0] KEY_1 = 4'd0;
  localparam logic [3:0] KEY_2 = 4'd1;
  localparam logic [3:0] KEY_3 = 4'd2;
  localparam logic [3:0] KEY_A = 4'd3;
  localparam logic [3:0] KEY_4 = 4'd4;
  localparam logic [3:0] KEY_5 = 4'd5;
  localparam logic [3:0] KEY_6 = 4'd6;
  localparam logic [3:0] KEY_B = 4'd7;
  localparam logic [3:0] KEY_7 = 4'd8;
  localparam logic [3:0] KEY_8 = 4'd9;
  localparam logic [3:0] KEY_9 = 4'd10;
  localparam logic [3:0] KEY_C = 4'd11;
  localparam logic [3:0] KEY_0 = 4'd13;
  localparam logic [3:0] KEY_HASH = 4'd14;
  localparam logic [3:0] KEY_D = 4'd15;

  // Character printed on each key, key code 0 in the top byte.
  localparam logic [127:0] KEY_GLYPHS = "123A456B789C*0#D";
  // Key code of each digit and of each reader letter, lowest value in the low nibble.
  localparam logic [39:0] DIGIT_KEYS = {KEY_9, KEY_8, KEY_7, KEY_6, KEY_5,
                                        KEY_4, KEY_3, KEY_2, KEY_1, KEY_0};
  localparam logic [15:0] LETTER_KEYS = {KEY_D, KEY_C, KEY_B, KEY_A};

  typedef struct {
    logic [3:0] key;
    bit         typed;
    res_t       result;
  } script_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [3:0]  key_code_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [4:0]  target_slot_o;
  logic [1:0]  reader_index_o;
  logic [14:0] step_count_o;
  logic        backward_o;
  logic        cfg_we_i;
  logic [11:0] cfg_wdata_i;

  // Shadow of the block: buffered keys, carousel position and steps per slot.
  logic [3:0]  held_keys [ENTRY_DEPTH];
  int          held_count;
  int          slot_now;
  logic [11:0] slot_steps;

  res_t        pending_results [$];
  script_row_t script [$];
  int unsigned fault_count;
  int unsigned results_checked;
  int unsigned keys_sent;
  int unsigned settings_used;
  int unsigned status_seen [4];
  int unsigned send_calm;
  int unsigned recv_calm;
  int unsigned quiet_cycles;

  keypad_slot_command_indexer #(
    .SLOT_COUNT(RING_SLOTS),
    .ENTRY_MAX (ENTRY_DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .key_code_i    (key_code_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .target_slot_o (target_slot_o),
    .reader_index_o(reader_index_o),
    .step_count_o  (step_count_o),
    .backward_o    (backward_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] glyph(input logic [3:0] code);
    return KEY_GLYPHS[8 * (15 - int'(code)) +: 8];
  endfunction

  // Wait before the next item; now and then a run of items goes with no wait at all.
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Checks the buffered entry on '*', moves the shadow carousel and clears the buffer.
  function automatic res_t resolve_entry();
    res_t        r;
    logic [7:0]  c [3];
    int          n;
    int          i;
    int          card;
    int          delta;
    int unsigned span;
    r = '0;
    n = held_count;
    held_count = 0;
    for (i = 0; i < 3; i++) c[i] = 8'h00;
    if (n > 3) begin
      r.status = ST_TOO_LONG;
      return r;
    end
    // A two-key entry is read as a one-digit card with a leading zero.
    if (n == 2) begin
      c[0] = "0";
      c[1] = glyph(held_keys[0]);
      c[2] = glyph(held_keys[1]);
      n = 3;
    end else begin
      for (i = 0; i < n; i++) c[i] = glyph(held_keys[i]);
    end
    // The reader letter is checked before the card number.
    if (n == 0 || c[n - 1] < "A" || c[n - 1] > "D") begin
      r.status = ST_BAD_READER;
      return r;
    end
    if ((c[0] != "1" && c[0] != "0") || c[1] < "0" || c[1] > "9" ||
        (c[0] == "1" && c[1] >= "7")) begin
      r.status = ST_BAD_CARD;
      return r;
    end
    card = int'(c[0] - "0") * 10 + int'(c[1] - "0");
    if (card > RING_SLOTS) card = RING_SLOTS;
    if (card < 1) card = 1;
    // Shortest way around the ring; a tie of half a turn goes the way it points.
    delta = card - slot_now;
    if (delta > RING_SLOTS / 2) delta -= RING_SLOTS;
    else if (delta < -(RING_SLOTS / 2)) delta += RING_SLOTS;
    span = (delta < 0 ? -delta : delta) * slot_steps;
    if (span > STEP_LIMIT) span = STEP_LIMIT;
    slot_now = card;
    r.status = ST_OK;
    r.target_slot = 5'(card);
    r.reader_index = 2'(c[2] - "A");
    r.step_count = 15'(span);
    r.backward = delta < 0;
    return r;
  endfunction

  // Feeds one key to the shadow; returns 1 when the key yields a result.
  function automatic bit apply_key(input logic [3:0] key, output res_t r);
    r = '0;
    if (key != KEY_STAR) begin
      if (held_count < ENTRY_DEPTH) begin
        held_keys[held_count] = key;
        held_count++;
      end
      return 1'b0;
    end
    r = resolve_entry();
    return 1'b1;
  endfunction

  function automatic void cue(input logic [3:0] key, input bit typed = 1'b0,
                              input status_e st = ST_OK, input int slot = 0,
                              input int reader = 0, input int steps = 0,
                              input bit back = 1'b0);
    script_row_t row;
    row.key = key;
    row.typed = typed;
    row.result.status = st;
    row.result.target_slot = 5'(slot);
    row.result.reader_index = 2'(reader);
    row.result.step_count = 15'(steps);
    row.result.backward = back;
    script.push_back(row);
  endfunction

  // One key transfer on the input channel, after a random gap.
  task automatic send_key(input logic [3:0] key, input bit typed, input res_t typed_result);
    int unsigned gap;
    res_t        predicted;
    gap = draw_wait(send_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_code_i <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // Keys dropped by a full buffer are not counted.
    if (key == KEY_STAR || held_count < ENTRY_DEPTH) keys_sent++;
    if (apply_key(key, predicted)) begin
      pending_results.push_back(typed ? typed_result : predicted);
    end
  endtask

  // Stops input and waits until every expected result has gone out.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_steps(input logic [11:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    slot_steps = value;
    settings_used++;
  endtask

  // Random command: mostly a card number and reader letter, otherwise any keys.
  task automatic send_command();
    int unsigned roll;
    int unsigned card;
    int unsigned len;
    int unsigned pick;
    int unsigned i;
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      card = $urandom_range(0, 19);
      if (card < 10 && $urandom_range(0, 1) == 1) begin
        send_key(DIGIT_KEYS[4 * card +: 4], 1'b0, '0);
      end else begin
        send_key(DIGIT_KEYS[4 * (card / 10) +: 4], 1'b0, '0);
        send_key(DIGIT_KEYS[4 * (card % 10) +: 4], 1'b0, '0);
      end
      pick = $urandom_range(0, 3);
      send_key(LETTER_KEYS[4 * pick +: 4], 1'b0, '0);
    end else begin
      len = $urandom_range(0, 7);
      for (i = 0; i < len; i++) send_key(4'($urandom_range(0, 15)), 1'b0, '0);
    end
    send_key(KEY_STAR, 1'b0, '0);
  endtask

  // Result side: random stalls, then each result transfer is checked in order.
  initial begin : result_sink
    int unsigned stall;
    res_t        want;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(recv_calm);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
          $display("%0t: result with none expected: status %0d slot %0d reader %0d",
                   $time, status_o, target_slot_o, reader_index_o);
          $display("%0t:      steps %0d back %0d", $time, step_count_o, backward_o);
        end
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        status_seen[want.status]++;
        if (status_o !== want.status || target_slot_o !== want.target_slot ||
            reader_index_o !== want.reader_index || step_count_o !== want.step_count ||
            backward_o !== want.backward) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("%0t: expected status %0d slot %0d reader %0d steps %0d back %0d",
                     $time, want.status, want.target_slot, want.reader_index,
                     want.step_count, want.backward);
            $display("%0t:      got status %0d slot %0d reader %0d steps %0d back %0d",
                     $time, status_o, target_slot_o, reader_index_o, step_count_o,
                     backward_o);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: reset, directed entries, then random phases at several step settings.
  initial begin : stimulus
    logic [11:0] phase_steps [PHASES];
    int unsigned target;
    int unsigned p;
    in_valid_i = 1'b0;
    key_code_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    quiet_cycles = 0;
    held_count = 0;
    slot_now = 1;
    slot_steps = STEPS_RESET;
    foreach (held_keys[i]) held_keys[i] = '0;

    // Directed entries; results that are obvious are written out here.
    cue(KEY_STAR, 1'b1, ST_BAD_READER);
    cue(KEY_5); cue(KEY_A);
    cue(KEY_STAR, 1'b1, ST_OK, 5, 0, 1608, 1'b0);
    cue(KEY_1); cue(KEY_6); cue(KEY_D);
    cue(KEY_STAR);
    cue(KEY_0); cue(KEY_B);
    cue(KEY_STAR, 1'b1, ST_OK, 1, 1, 402, 1'b0);
    cue(KEY_1); cue(KEY_7); cue(KEY_C);
    cue(KEY_STAR, 1'b1, ST_BAD_CARD);
    cue(KEY_A);
    cue(KEY_STAR, 1'b1, ST_BAD_CARD);
    cue(KEY_5);
    cue(KEY_STAR, 1'b1, ST_BAD_READER);
    cue(KEY_1); cue(KEY_2); cue(KEY_3); cue(KEY_HASH); cue(KEY_0); cue(KEY_D);
    cue(KEY_STAR, 1'b1, ST_TOO_LONG);

    phase_steps[0] = 12'd4095;
    phase_steps[1] = 12'd1;
    phase_steps[2] = 12'd0;
    phase_steps[3] = 12'($urandom_range(1, 4095));
    phase_steps[4] = 12'($urandom_range(1, 4095));
    phase_steps[5] = STEPS_RESET;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    write_steps(STEPS_RESET);
    foreach (script[i]) send_key(script[i].key, script[i].typed, script[i].result);

    for (p = 0; p < PHASES; p++) begin
      write_steps(phase_steps[p]);
      target = keys_sent + RANDOM_KEYS / PHASES;
      while (keys_sent < target) send_command();
    end
    drain_results();

    $display("Sent %0d keys over %0d step settings; checked %0d results", keys_sent,
             settings_used, results_checked);
    $display("(ok %0d, too long %0d, bad reader %0d, bad card %0d), %0d failures.",
             status_seen[ST_OK], status_seen[ST_TOO_LONG], status_seen[ST_BAD_READER],
             status_seen[ST_BAD_CARD], fault_count);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
